// ===== src/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property must hold on every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== src/sha256_pkg.sv =====
// shared types, constants and functions of the sha-256 engine
package sha256_pkg;
  localparam int QueueDepth = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // front to back command
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_byte;
  } cmd_t;

  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[i];
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h [8];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[i];
  endfunction
endpackage

// ===== src/sha256_front.sv =====
// front end: accepts transactions, drops idle ones, feeds the command queue
module sha256_front #(
  parameter int Depth = sha256_pkg::QueueDepth
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  sha256_pkg::in_item_t in_item,
  output logic                 cmd_valid,
  output sha256_pkg::cmd_t     cmd,
  input  logic                 cmd_take
);
  import sha256_pkg::*;
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t              q_r [Depth];
  logic [AW-1:0]     wp_r, rp_r;
  logic [AW:0]       cnt_r;
  logic              wr, rd;

  assign full      = (cnt_r == (AW+1)'(Depth));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rp_r];
  // idle transactions are accepted but not queued
  assign wr = push && !full && (in_item.byte_valid || in_item.last_byte);
  assign rd = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wp_r] <= '{data_byte: in_item.data_byte, byte_valid: in_item.byte_valid,
                     last_byte: in_item.last_byte};
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(Depth-1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(Depth-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end
endmodule

// ===== src/sha256_back.sv =====
// back end: block buffer, padding, compression rounds and digest output
module sha256_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  input  sha256_pkg::cmd_t      cmd,
  output logic                  cmd_take,
  output logic                  empty,
  input  logic                  pop,
  output sha256_pkg::out_item_t out_item
);
  import sha256_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_COMP = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  st_r;
  logic [31:0] w_r  [16];
  logic [31:0] h_r  [8];
  logic [31:0] v_r  [8];
  logic [63:0] len_r;
  logic [5:0]  fill_r;
  logic [5:0]  rnd_r;
  logic        ending_r;  // compression is part of message end
  logic        second_r;  // another padded block follows
  logic        padded_r;  // pad byte already placed for this message
  logic [2:0]  oidx_r;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] s1, ch, p, s0, mj, wnew, lo, hi;
  always_comb begin
    s1 = ror(v_r[4], 6) ^ ror(v_r[4], 11) ^ ror(v_r[4], 25);
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    p  = v_r[7] + s1 + ch + round_k(rnd_r) + w_r[0];
    s0 = ror(v_r[0], 2) ^ ror(v_r[0], 13) ^ ror(v_r[0], 22);
    mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    lo = ror(w_r[1], 7) ^ ror(w_r[1], 18) ^ (w_r[1] >> 3);
    hi = ror(w_r[14], 17) ^ ror(w_r[14], 19) ^ (w_r[14] >> 10);
    wnew = w_r[0] + lo + w_r[9] + hi;
  end

  assign cmd_take = (st_r == S_IDLE) && cmd_valid;
  assign empty    = (st_r != S_OUT);
  assign out_item = '{digest_word: h_r[oidx_r], word_index: oidx_r,
                      last_word: (oidx_r == 3'd7)};

  // write one byte into the word buffer
  task automatic put_byte(input logic [5:0] pos, input logic [7:0] b);
    w_r[pos[5:2]][8*(3-pos[1:0]) +: 8] <= b;
  endtask

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      len_r  <= '0;
      fill_r <= '0;
      rnd_r  <= '0;
      ending_r <= 1'b0;
      second_r <= 1'b0;
      padded_r <= 1'b0;
      oidx_r <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.byte_valid) begin
              put_byte(fill_r, cmd.data_byte);
              len_r  <= len_r + 64'd8;
              fill_r <= fill_r + 6'd1;
            end
            ending_r <= cmd.last_byte;
            if (cmd.byte_valid && fill_r == 6'd63) begin
              st_r  <= S_COMP;
              rnd_r <= '0;
              for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
            end else if (cmd.last_byte) begin
              st_r <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // fill position is the used count here
          for (int i = 0; i < 64; i++) begin
            if (6'(i) == fill_r) put_byte(6'(i), PadByte);
            else if (6'(i) > fill_r) put_byte(6'(i), 8'h00);
          end
          if (fill_r < 6'd56) begin
            w_r[14] <= len_r[63:32];
            w_r[15] <= len_r[31:0];
            second_r <= 1'b0;
          end else begin
            second_r <= 1'b1;
          end
          padded_r <= 1'b1;
          st_r  <= S_COMP;
          rnd_r <= '0;
          for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
        end
        S_COMP: begin
          for (int i = 7; i > 0; i--) v_r[i] <= v_r[i-1];
          v_r[4] <= v_r[3] + p;
          v_r[0] <= p + s0 + mj;
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= wnew;
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) st_r <= S_FIN;
        end
        S_FIN: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          fill_r <= '0;
          if (!ending_r) begin
            st_r <= S_IDLE;
          end else if (!padded_r) begin
            // full block ending a message still needs the pad block
            st_r <= S_PAD;
          end else if (second_r) begin
            for (int i = 0; i < 14; i++) w_r[i] <= '0;
            w_r[14]  <= len_r[63:32];
            w_r[15]  <= len_r[31:0];
            second_r <= 1'b0;
            st_r     <= S_COMP;
            rnd_r    <= '0;
            for (int i = 0; i < 8; i++) v_r[i] <= h_r[i] + v_r[i];
          end else begin
            st_r   <= S_OUT;
            oidx_r <= '0;
          end
        end
        S_OUT: begin
          if (pop) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              st_r     <= S_IDLE;
              len_r    <= '0;
              ending_r <= 1'b0;
              padded_r <= 1'b0;
              for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/sha256_hash_engine_top.sv =====
// top level of the sha-256 hash engine
// usage:
//   input queue: push a transaction with data_byte, byte_valid and last_byte
//   while full is low. a transaction with neither flag is dropped. a last mark
//   (with or without a byte) ends the message and triggers padding.
//   result queue: after a message end, eight digest words appear in order on
//   out_item while empty is low; each pop takes one, last_word marks word 7.
//   flow: the back end takes a byte per cycle while idle, and no bytes while a
//   block is compressed or the digest is read out. a full block is loaded, run
//   through 64 rounds of the single shared round unit and folded into the
//   chaining words; a message end adds padding and one or two compressions
//   before the first word. a four-entry command queue lets bytes arrive while a
//   block is compressed.
//   reset: synchronous active-low; clears the queue and loads the initial
//   chaining words. a stalled result queue holds the digest and backs up the
//   command queue until full rises.
`include "assert_macros.svh"
module sha256_hash_engine_top #(
  parameter int QueueDepth = sha256_pkg::QueueDepth
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  sha256_pkg::in_item_t  in_item,
  output logic                  empty,
  input  logic                  pop,
  output sha256_pkg::out_item_t out_item
);
  import sha256_pkg::*;

  logic cmd_valid, cmd_take;
  cmd_t cmd;

  sha256_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst_n, .push, .full, .in_item, .cmd_valid, .cmd, .cmd_take
  );

  sha256_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_take, .empty, .pop, .out_item
  );

  `ASSERT_NEXT(a_take_needs_valid, clk, rst_n, cmd_take, $past(cmd_valid), "take without command")
  `ASSERT_NEXT(a_last_word_ends, clk, rst_n, !empty && pop && out_item.last_word, empty, "digest burst overrun")
  `ASSERT_ALWAYS(a_idx_last, clk, rst_n, empty || (out_item.last_word == (out_item.word_index == 3'd7)), "last word mismatch")
endmodule

// ===== tb/sha256_hash_engine_top_test.sv =====
// testbench for the sha-256 hash engine: scoreboard with its own sha-256 predictor
module sha256_hash_engine_top_test;
  import sha256_pkg::*;

  class digest_scoreboard;
    logic [31:0] chain [8];
    logic [7:0]  blk [64];
    logic [63:0] msg_bits;
    logic [5:0]  fill;
    out_item_t   pending [$];
    int          errors;
    int          digests;
    logic [31:0] kk [64];
    logic [31:0] hh [8];

    function new();
      kk = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      hh = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
             32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      errors = 0;
      digests = 0;
      restart();
    endfunction

    function void restart();
      chain = hh;
      foreach (blk[i]) blk[i] = 8'h00;
      msg_bits = '0;
      fill = '0;
    endfunction

    function logic [31:0] rr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      for (int i = 0; i < 16; i++)
        w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 64; i++)
        w[i] = w[i-16] + (rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-7]
             + (rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10));
      v = chain;
      for (int i = 0; i < 64; i++) begin
        t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kk[i] + w[i];
        t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
    endfunction

    function void note_input(in_item_t it);
      out_item_t o;
      if (it.byte_valid) begin
        blk[fill] = it.data_byte;
        msg_bits += 64'd8;
        fill++;
        if (fill == 0) compress();
      end
      if (it.last_byte) begin
        blk[fill] = PadByte;
        for (int i = fill + 1; i < 64; i++) blk[i] = 8'h00;
        if (fill >= 56) begin
          compress();
          for (int i = 0; i < 56; i++) blk[i] = 8'h00;
        end
        for (int i = 0; i < 8; i++) blk[63-i] = msg_bits[8*i +: 8];
        compress();
        for (int i = 0; i < 8; i++) begin
          o.digest_word = chain[i];
          o.word_index = i[2:0];
          o.last_word = (i == 7);
          pending.push_back(o);
        end
        restart();
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.digest_word !== want.digest_word) begin
        $display("%0t: digest_word expected %h actual %h", $time, want.digest_word,
                 got.digest_word);
        errors++;
      end
      if (got.word_index !== want.word_index) begin
        $display("%0t: word_index expected %0d actual %0d", $time, want.word_index,
                 got.word_index);
        errors++;
      end
      if (got.last_word !== want.last_word) begin
        $display("%0t: last_word expected %0d actual %0d", $time, want.last_word,
                 got.last_word);
        errors++;
      end
      if (got.last_word === 1'b1) digests++;
    endfunction
  endclass

  logic clk, rst_n, push, full, empty, pop;
  in_item_t in_item;
  out_item_t out_item;
  digest_scoreboard sb;
  int cycles;
  int sent;
  int stall_mode;

  sha256_hash_engine_top DUT (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    sb = new();
    rst_n = 0;
    push = 0;
    pop = 0;
    in_item = '0;
    cycles = 0;
    sent = 0;
    stall_mode = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: checks popped words; stall pattern is redrawn at random from four modes
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) sb.check_result(out_item);
      if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: pop <= 1'b1;
        1: pop <= ($urandom_range(0, 3) != 0);
        2: pop <= ($urandom_range(0, 3) == 0);
        default: pop <= ((cycles % 16) < 4);
      endcase
    end
  end

  task automatic send_item(input logic [7:0] d, input logic v, input logic l);
    push <= 1'b1;
    in_item <= '{data_byte: d, byte_valid: v, last_byte: l};
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_input(in_item);
    sent++;
  endtask

  task automatic gap();
    int n;
    n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_message(input int len, input bit mark_on_byte);
    for (int i = 0; i < len; i++) begin
      if (i == len - 1 && mark_on_byte) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      else send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      if ($urandom_range(0, 7) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      gap();
    end
    if (!mark_on_byte || len == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    int len;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: empty message, idle items, extremes, block boundaries
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    drain();
    send_message(55, 1);
    send_message(56, 1);
    send_message(64, 0);
    drain();
    // random messages, mostly short, a few past one block
    while (sent < 210) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(56, 130) : $urandom_range(0, 12);
      send_message(len, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 9) == 0) drain();
    end
    drain();
    $display("%0d transactions sent, %0d digests checked, messages from empty to multi-block",
             sent, sb.digests);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
